// File: hw/rtl/dhrp_pkg.sv
// ----------------------------------------------------------------------------
// Diff hunk range parser package
// Shared widths, codes, request and result types, and the literal tables
// used by the character parser.
// ----------------------------------------------------------------------------
package dhrp_pkg;

  // Width of a parsed line number; numbers above 2^LineBits - 1 fail the line.
  localparam int unsigned LineBits = 31;
  // Widths of the result fields.
  localparam int unsigned ResBits  = 31;
  localparam int unsigned CntBits  = 32;
  // Width used to compute the new count before it is cut to the result.
  localparam int unsigned CalcBits = (LineBits > CntBits) ? LineBits : CntBits;

  // Character codes.
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowC  = 8'h63;
  localparam logic [7:0] ChLowD  = 8'h64;

  // Header formats selected by the configuration register.
  localparam logic FmtUnified = 1'b0;
  localparam logic FmtNormal  = 1'b1;

  // Parse phases.
  typedef enum logic [3:0] {
    PH_FIRST       = 4'd0,
    PH_U_OLD_START = 4'd1,
    PH_U_OLD_COUNT = 4'd2,
    PH_U_LIT_PLUS  = 4'd3,
    PH_U_NEW_START = 4'd4,
    PH_U_NEW_COUNT = 4'd5,
    PH_U_LIT_END   = 4'd6,
    PH_U_DONE      = 4'd7,
    PH_N_OLD_END   = 4'd8,
    PH_N_NEW_START = 4'd9,
    PH_N_NEW_END   = 4'd10
  } phase_e;

  // Normal-diff command letters.
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_CHANGE = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  // Fixed literals of the unified header.
  typedef enum logic [1:0] {
    LIT_OPEN,
    LIT_PLUS,
    LIT_CLOSE
  } lit_e;

  // One input request.
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } item_t;

  // One result.
  typedef struct packed {
    logic                      valid_res;
    logic [ResBits-1:0]        old_start;
    logic [ResBits-1:0]        old_count;
    logic [ResBits-1:0]        new_start;
    logic signed [CntBits-1:0] new_count;
  } result_t;

  // Expected character at a position of a literal.
  function automatic logic [7:0] lit_char(lit_e sel, logic [1:0] pos);
    logic [7:0] ch;
    ch = ChSpace;
    case (sel)
      LIT_OPEN: begin
        case (pos)
          2'd0:    ch = ChAt;
          2'd1:    ch = ChAt;
          2'd2:    ch = ChSpace;
          default: ch = ChMinus;
        endcase
      end
      LIT_PLUS: begin
        ch = (pos == 2'd0) ? ChSpace : ChPlus;
      end
      default: begin
        ch = (pos == 2'd0) ? ChSpace : ChAt;
      end
    endcase
    return ch;
  endfunction

  // Length of a literal.
  function automatic logic [2:0] lit_len(lit_e sel);
    logic [2:0] len;
    case (sel)
      LIT_OPEN: len = 3'd4;
      LIT_PLUS: len = 3'd2;
      default:  len = 3'd3;
    endcase
    return len;
  endfunction

  // Cuts a line number to the width of a result field.
  function automatic logic [ResBits-1:0] to_res(logic [LineBits-1:0] v);
    logic [CalcBits-1:0] w;
    w = CalcBits'(v);
    return w[ResBits-1:0];
  endfunction

endpackage

// File: hw/rtl/dhrp_in_reg.sv
// ----------------------------------------------------------------------------
// Diff hunk range parser input register
// Holds one request for the parser. It takes a new request in the same
// cycle in which the held one moves on.
// ----------------------------------------------------------------------------
module dhrp_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dhrp_pkg::item_t in_item_i,
  output logic           item_valid_o,
  output dhrp_pkg::item_t item_o,
  input  logic           item_take_i
);

  logic            valid_q, valid_d;
  dhrp_pkg::item_t item_q;
  logic            load;

  // The register is free when empty or when its request is taken now.
  assign in_stall_o = valid_q && !item_take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: hw/rtl/dhrp_parser.sv
// ----------------------------------------------------------------------------
// Diff hunk range parser step
// Holds the line state and advances it by one character per cycle. On the
// end-of-line request it forms the result and clears the line state.
// ----------------------------------------------------------------------------
module dhrp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              item_valid_i,
  input  dhrp_pkg::item_t   item_i,
  output logic              item_take_o,
  input  logic              res_ready_i,
  output logic              res_push_o,
  output dhrp_pkg::result_t res_o
);

  localparam int unsigned LB = dhrp_pkg::LineBits;
  localparam int unsigned CB = dhrp_pkg::CalcBits;

  logic                fmt_q, fmt_d;
  dhrp_pkg::phase_e    phase_q, phase_d;
  logic [1:0]          pos_q, pos_d;
  logic [LB-1:0]       acc_q, acc_d;
  logic                seen_q, seen_d;
  logic [LB-1:0]       v1_q, v1_d;
  logic [LB-1:0]       v2_q, v2_d;
  logic [LB-1:0]       v3_q, v3_d;
  logic [LB-1:0]       v4_q, v4_d;
  logic [1:0]          comma_q, comma_d;
  dhrp_pkg::cmd_e      cmd_q, cmd_d;
  logic                failed_q, failed_d;

  logic [7:0]          ch;
  logic                digit_hit;
  logic [LB+3:0]       prod;
  logic                ovf;
  dhrp_pkg::lit_e      lit_sel;
  dhrp_pkg::phase_e    lit_next;
  logic [2:0]          lit_len;
  logic                lit_ok;
  logic                lit_last;
  logic                clear_line;
  logic                is_cmd;
  dhrp_pkg::cmd_e      cmd_code;

  logic                ok;
  logic [LB-1:0]       end_v;
  logic [LB-1:0]       ns_v;
  logic [CB-1:0]       nc_full;
  logic [dhrp_pkg::ResBits-1:0] oc_v;

  // A character moves on every cycle; an end of line needs room for the result.
  assign item_take_o = item_valid_i && (!item_i.end_of_line || res_ready_i);
  assign res_push_o  = item_take_o && item_i.end_of_line;
  assign clear_line  = cfg_we_i || res_push_o;

  // Decimal digit accumulate: acc * 10 + digit, with overflow out of LB bits.
  assign ch        = item_i.char_code;
  assign digit_hit = (ch >= dhrp_pkg::ChZero) && (ch <= dhrp_pkg::ChNine);
  assign prod      = ((LB+4)'(acc_q) << 3) + ((LB+4)'(acc_q) << 1) + (LB+4)'(ch[3:0]);
  assign ovf       = |prod[LB+3:LB];

  // Literal matcher for the literal that belongs to the current phase.
  always_comb begin
    case (phase_q)
      dhrp_pkg::PH_FIRST: begin
        lit_sel  = dhrp_pkg::LIT_OPEN;
        lit_next = dhrp_pkg::PH_U_OLD_START;
      end
      dhrp_pkg::PH_U_OLD_START, dhrp_pkg::PH_U_OLD_COUNT, dhrp_pkg::PH_U_LIT_PLUS: begin
        lit_sel  = dhrp_pkg::LIT_PLUS;
        lit_next = dhrp_pkg::PH_U_NEW_START;
      end
      default: begin
        lit_sel  = dhrp_pkg::LIT_CLOSE;
        lit_next = dhrp_pkg::PH_U_DONE;
      end
    endcase
  end

  assign lit_len  = dhrp_pkg::lit_len(lit_sel);
  assign lit_ok   = ({1'b0, pos_q} < lit_len) && (ch == dhrp_pkg::lit_char(lit_sel, pos_q));
  assign lit_last = (({1'b0, pos_q} + 3'd1) == lit_len);

  // Command letter decode.
  always_comb begin
    is_cmd   = 1'b1;
    cmd_code = dhrp_pkg::CMD_NONE;
    case (ch)
      dhrp_pkg::ChLowA: cmd_code = dhrp_pkg::CMD_ADD;
      dhrp_pkg::ChLowC: cmd_code = dhrp_pkg::CMD_CHANGE;
      dhrp_pkg::ChLowD: cmd_code = dhrp_pkg::CMD_DELETE;
      default:          is_cmd   = 1'b0;
    endcase
  end

  // Next line state for one character.
  always_comb begin
    fmt_d    = fmt_q;
    phase_d  = phase_q;
    pos_d    = pos_q;
    acc_d    = acc_q;
    seen_d   = seen_q;
    v1_d     = v1_q;
    v2_d     = v2_q;
    v3_d     = v3_q;
    v4_d     = v4_q;
    comma_d  = comma_q;
    cmd_d    = cmd_q;
    failed_d = failed_q;

    if (clear_line) begin
      if (cfg_we_i) begin
        fmt_d = cfg_wdata_i;
      end
      phase_d  = dhrp_pkg::PH_FIRST;
      pos_d    = '0;
      acc_d    = '0;
      seen_d   = 1'b0;
      v1_d     = '0;
      v2_d     = '0;
      v3_d     = '0;
      v4_d     = '0;
      comma_d  = '0;
      cmd_d    = dhrp_pkg::CMD_NONE;
      failed_d = 1'b0;
    end else if (item_take_o && !failed_q) begin
      if (digit_hit && phase_q != dhrp_pkg::PH_U_DONE && phase_q != dhrp_pkg::PH_U_LIT_PLUS &&
          phase_q != dhrp_pkg::PH_U_LIT_END &&
          !(phase_q == dhrp_pkg::PH_FIRST && fmt_q == dhrp_pkg::FmtUnified)) begin
        // A digit extends the number being read.
        if (ovf) begin
          failed_d = 1'b1;
        end else begin
          acc_d = prod[LB-1:0];
        end
        seen_d = 1'b1;
      end else begin
        case (phase_q)
          dhrp_pkg::PH_FIRST: begin
            if (fmt_q == dhrp_pkg::FmtUnified) begin
              if (lit_ok) begin
                if (lit_last) begin
                  pos_d   = '0;
                  phase_d = lit_next;
                end else begin
                  pos_d = pos_q + 2'd1;
                end
              end else begin
                failed_d = 1'b1;
              end
            end else if (!seen_q) begin
              failed_d = 1'b1;
            end else begin
              v1_d   = acc_q;
              acc_d  = '0;
              seen_d = 1'b0;
              if (ch == dhrp_pkg::ChComma) begin
                comma_d[0] = 1'b1;
                phase_d    = dhrp_pkg::PH_N_OLD_END;
              end else if (is_cmd) begin
                cmd_d   = cmd_code;
                phase_d = dhrp_pkg::PH_N_NEW_START;
              end else begin
                failed_d = 1'b1;
              end
            end
          end
          dhrp_pkg::PH_U_OLD_START, dhrp_pkg::PH_U_OLD_COUNT,
          dhrp_pkg::PH_U_NEW_START, dhrp_pkg::PH_U_NEW_COUNT: begin
            // Close the number, then either a comma or the following literal.
            if (!seen_q) begin
              failed_d = 1'b1;
            end else begin
              acc_d  = '0;
              seen_d = 1'b0;
              case (phase_q)
                dhrp_pkg::PH_U_OLD_START: v1_d = acc_q;
                dhrp_pkg::PH_U_OLD_COUNT: v2_d = acc_q;
                dhrp_pkg::PH_U_NEW_START: v3_d = acc_q;
                default:                  v4_d = acc_q;
              endcase
              if (ch == dhrp_pkg::ChComma && phase_q == dhrp_pkg::PH_U_OLD_START) begin
                comma_d[0] = 1'b1;
                phase_d    = dhrp_pkg::PH_U_OLD_COUNT;
              end else if (ch == dhrp_pkg::ChComma &&
                           phase_q == dhrp_pkg::PH_U_NEW_START) begin
                comma_d[1] = 1'b1;
                phase_d    = dhrp_pkg::PH_U_NEW_COUNT;
              end else if (lit_ok) begin
                if (lit_last) begin
                  pos_d   = '0;
                  phase_d = lit_next;
                end else begin
                  pos_d   = pos_q + 2'd1;
                  phase_d = (lit_sel == dhrp_pkg::LIT_PLUS) ? dhrp_pkg::PH_U_LIT_PLUS
                                                            : dhrp_pkg::PH_U_LIT_END;
                end
              end else begin
                failed_d = 1'b1;
              end
            end
          end
          dhrp_pkg::PH_U_LIT_PLUS, dhrp_pkg::PH_U_LIT_END: begin
            if (lit_ok) begin
              if (lit_last) begin
                pos_d   = '0;
                phase_d = lit_next;
              end else begin
                pos_d = pos_q + 2'd1;
              end
            end else begin
              failed_d = 1'b1;
            end
          end
          dhrp_pkg::PH_U_DONE: begin
            // Trailing text after the closing literal is ignored.
          end
          dhrp_pkg::PH_N_OLD_END: begin
            if (!seen_q || !is_cmd) begin
              failed_d = 1'b1;
            end else begin
              v2_d    = acc_q;
              acc_d   = '0;
              seen_d  = 1'b0;
              cmd_d   = cmd_code;
              phase_d = dhrp_pkg::PH_N_NEW_START;
            end
          end
          dhrp_pkg::PH_N_NEW_START: begin
            // Only a change command may carry a comma on both sides.
            if (!seen_q || ch != dhrp_pkg::ChComma ||
                (comma_q[0] && cmd_q != dhrp_pkg::CMD_CHANGE)) begin
              failed_d = 1'b1;
            end else begin
              v3_d       = acc_q;
              acc_d      = '0;
              seen_d     = 1'b0;
              comma_d[1] = 1'b1;
              phase_d    = dhrp_pkg::PH_N_NEW_END;
            end
          end
          default: begin
            failed_d = 1'b1;
          end
        endcase
      end
    end
  end

  // Result at the end of the line.
  always_comb begin
    ok      = 1'b0;
    ns_v    = v3_q;
    end_v   = acc_q;
    nc_full = '0;
    oc_v    = '0;
    res_o   = '0;
    if (!failed_q) begin
      if (phase_q == dhrp_pkg::PH_U_DONE) begin
        ok = 1'b1;
      end else if (phase_q == dhrp_pkg::PH_N_NEW_START ||
                   phase_q == dhrp_pkg::PH_N_NEW_END) begin
        ok = seen_q;
      end
    end
    if (phase_q == dhrp_pkg::PH_N_NEW_START) begin
      ns_v = acc_q;
    end
    nc_full = CB'(end_v) - CB'(ns_v) + CB'(1) -
              ((cmd_q == dhrp_pkg::CMD_DELETE) ? CB'(1) : CB'(0));
    if (comma_q[0]) begin
      oc_v = dhrp_pkg::to_res(v2_q);
    end else if (cmd_q == dhrp_pkg::CMD_ADD) begin
      oc_v = '0;
    end else begin
      oc_v = dhrp_pkg::ResBits'(1);
    end

    if (ok) begin
      res_o.valid_res = 1'b1;
      res_o.old_start = dhrp_pkg::to_res(v1_q);
      if (phase_q == dhrp_pkg::PH_U_DONE) begin
        res_o.old_count = comma_q[0] ? dhrp_pkg::to_res(v2_q) : dhrp_pkg::ResBits'(1);
        res_o.new_start = dhrp_pkg::to_res(v3_q);
        res_o.new_count = comma_q[1] ? dhrp_pkg::CntBits'(dhrp_pkg::to_res(v4_q))
                                     : dhrp_pkg::CntBits'(1);
      end else begin
        res_o.old_count = oc_v;
        res_o.new_start = dhrp_pkg::to_res(ns_v);
        res_o.new_count = nc_full[dhrp_pkg::CntBits-1:0];
      end
    end
  end

  // Line state and format register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= dhrp_pkg::FmtUnified;
      phase_q  <= dhrp_pkg::PH_FIRST;
      pos_q    <= '0;
      acc_q    <= '0;
      seen_q   <= 1'b0;
      v1_q     <= '0;
      v2_q     <= '0;
      v3_q     <= '0;
      v4_q     <= '0;
      comma_q  <= '0;
      cmd_q    <= dhrp_pkg::CMD_NONE;
      failed_q <= 1'b0;
    end else begin
      fmt_q    <= fmt_d;
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      acc_q    <= acc_d;
      seen_q   <= seen_d;
      v1_q     <= v1_d;
      v2_q     <= v2_d;
      v3_q     <= v3_d;
      v4_q     <= v4_d;
      comma_q  <= comma_d;
      cmd_q    <= cmd_d;
      failed_q <= failed_d;
    end
  end

endmodule

// File: hw/rtl/dhrp_out_reg.sv
// ----------------------------------------------------------------------------
// Diff hunk range parser output register
// Holds one result until the consumer takes it, and can load the next
// result in the cycle the held one leaves.
// ----------------------------------------------------------------------------
module dhrp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_push_i,
  input  dhrp_pkg::result_t res_i,
  output logic              res_ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dhrp_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  dhrp_pkg::result_t res_q;

  // Room when empty or when the held result is taken now.
  assign res_ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (res_push_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (res_push_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// File: hw/rtl/diff_hunk_range_parser_core.sv
// ----------------------------------------------------------------------------
// Diff hunk range parser
// Parses one diff hunk header line, one character per request, into the
// old and new line ranges.
// ----------------------------------------------------------------------------
// Each request carries one character of a header line or an end-of-line
// marker; only the end-of-line request produces a result. The block takes
// one request per cycle unless an end-of-line request waits for the result
// register, bounded by the single per-character state update (a times-ten
// accumulate and a phase step) between the input register and the line
// state. A result waits in the result register from when its end-of-line
// request leaves the input register until taken, while characters keep
// flowing in. Writing the format register discards the line in progress.
module diff_hunk_range_parser_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          char_code_i,
  input  logic                                end_of_line_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                valid_res_o,
  output logic [dhrp_pkg::ResBits-1:0]        old_start_o,
  output logic [dhrp_pkg::ResBits-1:0]        old_count_o,
  output logic [dhrp_pkg::ResBits-1:0]        new_start_o,
  output logic signed [dhrp_pkg::CntBits-1:0] new_count_o
);

  dhrp_pkg::item_t   in_item;
  dhrp_pkg::item_t   item;
  logic              item_valid;
  logic              item_take;
  logic              res_ready;
  logic              res_push;
  dhrp_pkg::result_t res_next;
  dhrp_pkg::result_t res_out;

  assign in_item.char_code   = char_code_i;
  assign in_item.end_of_line = end_of_line_i;

  // Input register.
  dhrp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  // Character parser and line state.
  dhrp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_ready_i  (res_ready),
    .res_push_o   (res_push),
    .res_o        (res_next)
  );

  // Result register.
  dhrp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_push_i  (res_push),
    .res_i       (res_next),
    .res_ready_o (res_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign valid_res_o = res_out.valid_res;
  assign old_start_o = res_out.old_start;
  assign old_count_o = res_out.old_count;
  assign new_start_o = res_out.new_start;
  assign new_count_o = res_out.new_count;

endmodule

// File: tb/hunk_range_checker.sv
// ----------------------------------------------------------------------------
// Hunk range checker
// Watches the configuration port and both request channels of the diff hunk
// range parser, predicts the range result of every header line and compares
// each accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module hunk_range_checker
  import dhrp_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [7:0]                 char_code_i,
  input  logic                       end_of_line_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic                       valid_res_i,
  input  logic [ResBits-1:0]         old_start_i,
  input  logic [ResBits-1:0]         old_count_i,
  input  logic [ResBits-1:0]         new_start_i,
  input  logic signed [CntBits-1:0]  new_count_i,
  output int unsigned                mismatches_o,
  output int unsigned                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Largest line number that fits the parser's line width.
  localparam logic [63:0] LineMax = (64'd1 << LineBits) - 64'd1;
  localparam int unsigned ReportLimit = 10;

  // Shadow copy of the format register and of the line state.
  logic        header_fmt = FmtUnified;
  phase_e      parse_phase = PH_FIRST;
  int unsigned lit_pos = 0;
  logic [63:0] number_acc = '0;
  bit          digit_seen = 1'b0;
  logic [63:0] first_v = '0;
  logic [63:0] second_v = '0;
  logic [63:0] third_v = '0;
  logic [63:0] fourth_v = '0;
  logic [63:0] closed_num = '0;
  logic [1:0]  comma_seen = '0;
  cmd_e        command = CMD_NONE;
  bit          line_failed = 1'b0;

  result_t     expected_ranges[$];
  result_t     got_range;
  result_t     want_range;
  int unsigned mismatch_count = 0;
  int unsigned pending_count = 0;
  int unsigned result_index = 0;

  assign mismatches_o = mismatch_count;
  assign pending_o    = pending_count;

  function automatic void clear_line();
    parse_phase = PH_FIRST;
    lit_pos     = 0;
    number_acc  = '0;
    digit_seen  = 1'b0;
    first_v     = '0;
    second_v    = '0;
    third_v     = '0;
    fourth_v    = '0;
    comma_seen  = '0;
    command     = CMD_NONE;
    line_failed = 1'b0;
  endfunction

  // Accumulates a decimal digit; an overflow fails the line but the byte
  // still counts as a digit.
  function automatic bit take_digit(logic [7:0] c);
    logic [63:0] d;
    if (c < "0" || c > "9") return 1'b0;
    d = {56'd0, 8'(c - "0")};
    if (number_acc > LineMax / 10 || number_acc * 10 > LineMax - d) begin
      line_failed = 1'b1;
    end else begin
      number_acc = number_acc * 10 + d;
    end
    digit_seen = 1'b1;
    return 1'b1;
  endfunction

  // Closes the number in progress into closed_num; an empty number fails.
  function automatic bit close_number();
    if (!digit_seen) begin
      line_failed = 1'b1;
      return 1'b0;
    end
    closed_num = number_acc;
    number_acc = '0;
    digit_seen = 1'b0;
    return 1'b1;
  endfunction

  // True when c is not a digit and ends a well-formed number.
  function automatic bit number_ends(logic [7:0] c);
    if (take_digit(c)) return 1'b0;
    return close_number();
  endfunction

  // Matches c against position lit_pos of a right-aligned literal.
  function automatic void match_lit(logic [7:0] c, logic [31:0] lit, int unsigned len,
                                    phase_e nxt);
    if (lit_pos < len && c == lit[8*(len-1-lit_pos) +: 8]) begin
      lit_pos++;
      if (lit_pos == len) begin
        lit_pos     = 0;
        parse_phase = nxt;
      end
    end else begin
      line_failed = 1'b1;
    end
  endfunction

  function automatic void take_command(logic [7:0] c);
    if (c == "a") begin
      command = CMD_ADD;
    end else if (c == "c") begin
      command = CMD_CHANGE;
    end else if (c == "d") begin
      command = CMD_DELETE;
    end else begin
      line_failed = 1'b1;
      return;
    end
    parse_phase = PH_N_NEW_START;
  endfunction

  // One character of the line.
  function automatic void parse_byte(logic [7:0] c);
    case (parse_phase)
      PH_FIRST: begin
        if (header_fmt == FmtUnified) begin
          match_lit(c, "@@ -", 4, PH_U_OLD_START);
        end else if (number_ends(c)) begin
          first_v = closed_num;
          if (c == ",") begin
            comma_seen[0] = 1'b1;
            parse_phase   = PH_N_OLD_END;
          end else begin
            take_command(c);
          end
        end
      end
      PH_U_OLD_START: begin
        if (number_ends(c)) begin
          first_v = closed_num;
          if (c == ",") begin
            comma_seen[0] = 1'b1;
            parse_phase   = PH_U_OLD_COUNT;
          end else begin
            parse_phase = PH_U_LIT_PLUS;
            match_lit(c, " +", 2, PH_U_NEW_START);
          end
        end
      end
      PH_U_OLD_COUNT: begin
        if (number_ends(c)) begin
          second_v    = closed_num;
          parse_phase = PH_U_LIT_PLUS;
          match_lit(c, " +", 2, PH_U_NEW_START);
        end
      end
      PH_U_LIT_PLUS: begin
        match_lit(c, " +", 2, PH_U_NEW_START);
      end
      PH_U_NEW_START: begin
        if (number_ends(c)) begin
          third_v = closed_num;
          if (c == ",") begin
            comma_seen[1] = 1'b1;
            parse_phase   = PH_U_NEW_COUNT;
          end else begin
            parse_phase = PH_U_LIT_END;
            match_lit(c, " @@", 3, PH_U_DONE);
          end
        end
      end
      PH_U_NEW_COUNT: begin
        if (number_ends(c)) begin
          fourth_v    = closed_num;
          parse_phase = PH_U_LIT_END;
          match_lit(c, " @@", 3, PH_U_DONE);
        end
      end
      PH_U_LIT_END: begin
        match_lit(c, " @@", 3, PH_U_DONE);
      end
      PH_U_DONE: begin
      end
      PH_N_OLD_END: begin
        if (number_ends(c)) begin
          second_v = closed_num;
          take_command(c);
        end
      end
      PH_N_NEW_START: begin
        if (number_ends(c)) begin
          third_v = closed_num;
          // A second comma is only allowed on a change command or without a first one.
          if (c == "," && !(comma_seen[0] && command != CMD_CHANGE)) begin
            comma_seen[1] = 1'b1;
            parse_phase   = PH_N_NEW_END;
          end else begin
            line_failed = 1'b1;
          end
        end
      end
      PH_N_NEW_END: begin
        if (!take_digit(c)) line_failed = 1'b1;
      end
      default: begin
        line_failed = 1'b1;
      end
    endcase
  endfunction

  // End of line: builds the expected result and clears the line state.
  function automatic result_t finish_line();
    result_t     r;
    logic [63:0] os, oc, ns, nc;
    bit          ok;
    ok = 1'b0;
    os = '0;
    oc = '0;
    ns = '0;
    nc = '0;
    if (!line_failed) begin
      if (parse_phase == PH_U_DONE) begin
        ok = 1'b1;
        os = first_v;
        oc = comma_seen[0] ? second_v : 64'd1;
        ns = third_v;
        nc = comma_seen[1] ? fourth_v : 64'd1;
      end else if (parse_phase == PH_N_NEW_START || parse_phase == PH_N_NEW_END) begin
        if (close_number()) begin
          ok = 1'b1;
          if (parse_phase == PH_N_NEW_START) third_v = closed_num;
          else fourth_v = closed_num;
          os = first_v;
          if (comma_seen[0]) oc = second_v;
          else oc = (command == CMD_ADD) ? 64'd0 : 64'd1;
          ns = third_v;
          nc = closed_num - ns + 64'd1;
          if (command == CMD_DELETE) nc = nc - 64'd1;
        end
      end
    end
    if (!ok) begin
      os = '0;
      oc = '0;
      ns = '0;
      nc = '0;
    end
    r.valid_res = ok;
    r.old_start = os[ResBits-1:0];
    r.old_count = oc[ResBits-1:0];
    r.new_start = ns[ResBits-1:0];
    r.new_count = nc[CntBits-1:0];
    clear_line();
    return r;
  endfunction

  function automatic void note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("%0t: result %0d %s: expected valid=%0b %0d,%0d %0d,%0d got valid=%0b %0d,%0d %0d,%0d",
               $time, result_index, what, want_range.valid_res, want_range.old_start,
               want_range.old_count, want_range.new_start, want_range.new_count,
               got_range.valid_res, got_range.old_start, got_range.old_count,
               got_range.new_start, got_range.new_count);
    end
  endfunction

  // Follow the configuration writes and both channels at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_fmt = FmtUnified;
      clear_line();
      expected_ranges.delete();
      pending_count = 0;
    end else begin
      if (cfg_we_i) begin
        header_fmt = cfg_wdata_i;
        clear_line();
      end
      if (in_valid_i && !in_stall_i) begin
        if (end_of_line_i) expected_ranges = {expected_ranges, finish_line()};
        else if (!line_failed) parse_byte(char_code_i);
      end
      if (out_valid_i && !out_stall_i) begin
        got_range.valid_res = valid_res_i;
        got_range.old_start = old_start_i;
        got_range.old_count = old_count_i;
        got_range.new_start = new_start_i;
        got_range.new_count = new_count_i;
        if (expected_ranges.size() == 0) begin
          want_range = '0;
          note_mismatch("with no line pending");
        end else begin
          want_range = expected_ranges.pop_front();
          if (got_range.valid_res !== want_range.valid_res
              || got_range.old_start !== want_range.old_start
              || got_range.old_count !== want_range.old_count
              || got_range.new_start !== want_range.new_start
              || got_range.new_count !== want_range.new_count) begin
            note_mismatch("differs");
          end
        end
        result_index++;
      end
      pending_count = expected_ranges.size();
    end
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Diff hunk range parser testbench
// Feeds header lines of both formats, well-formed, damaged and random, into
// the parser under varying idle and stall patterns and register settings;
// the range checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dhrp_pkg::*;

  localparam int unsigned ItemTarget  = 1950;
  localparam int unsigned PhaseItems  = 250;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned HoldCycles  = 64;
  localparam int unsigned CycleLimit  = 200000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic                      cfg_wdata = 1'b0;
  logic                      in_valid = 1'b0;
  logic [7:0]                char_code = '0;
  logic                      end_of_line = 1'b0;
  logic                      out_stall = 1'b0;
  logic                      in_stall;
  logic                      out_valid;
  logic                      valid_res;
  logic [ResBits-1:0]        old_start;
  logic [ResBits-1:0]        old_count;
  logic [ResBits-1:0]        new_start;
  logic signed [CntBits-1:0] new_count;
  int unsigned               mismatches;
  int unsigned               pending;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  logic        cur_fmt = FmtUnified;
  logic [7:0]  line_q[$];

  diff_hunk_range_parser_core uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .char_code_i   (char_code),
    .end_of_line_i (end_of_line),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .valid_res_o   (valid_res),
    .old_start_o   (old_start),
    .old_count_o   (old_count),
    .new_start_o   (new_start),
    .new_count_o   (new_count)
  );

  hunk_range_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .char_code_i   (char_code),
    .end_of_line_i (end_of_line),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .valid_res_i   (valid_res),
    .old_start_i   (old_start),
    .old_count_i   (old_count),
    .new_start_i   (new_start),
    .new_count_i   (new_count),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop for a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result receiver: random stalls, plus long hold-offs on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_served < holds_asked) begin
      holds_served++;
      hold_left = HoldCycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Offers one request after random idle cycles; returns at the falling edge
  // after it was accepted.
  task automatic send_item(logic [7:0] c, logic eol);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    char_code   <= c;
    end_of_line <= eol;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_bytes();
    foreach (line_q[i]) send_item(line_q[i], 1'b0);
  endtask

  // The end-of-line request carries a random, ignored character.
  task automatic send_line();
    send_bytes();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Appends one byte to the line being built.
  function automatic void add_byte(logic [7:0] b);
    line_q = {line_q, b};
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  task automatic send_text(string s);
    line_q.delete();
    put_str(s);
    send_line();
  endtask

  // Mostly small numbers, with the edges of the line-number range and
  // overflowing digit runs now and then.
  function automatic void put_num();
    int unsigned kind;
    logic [63:0] v;
    kind = $urandom_range(0, 19);
    if (kind < 12) begin
      v = $urandom_range(0, 20);
    end else if (kind < 15) begin
      v = $urandom_range(0, 99999);
    end else if (kind == 15) begin
      v = 64'd2147483647;
    end else if (kind == 16) begin
      v = 64'd2147483648 + $urandom_range(0, 3);
    end else if (kind == 17) begin
      v = {33'd0, 31'($urandom)};
    end else if (kind == 18) begin
      put_str("00");
      v = $urandom_range(0, 9);
    end else begin
      repeat ($urandom_range(10, 13)) add_byte(8'("0" + $urandom_range(0, 9)));
      return;
    end
    put_str($sformatf("%0d", v));
  endfunction

  function automatic void build_unified();
    put_str("@@ -");
    put_num();
    if ($urandom_range(0, 1)) begin
      put_str(",");
      put_num();
    end
    put_str(" +");
    put_num();
    if ($urandom_range(0, 1)) begin
      put_str(",");
      put_num();
    end
    put_str(" @@");
    if ($urandom_range(0, 1)) begin
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void build_normal();
    string letters;
    logic [7:0] letter;
    letters = "acd";
    put_num();
    if ($urandom_range(0, 99) < 35) begin
      put_str(",");
      put_num();
    end
    letter = letters[$urandom_range(0, 2)];
    add_byte(letter);
    put_num();
    if ($urandom_range(0, 99) < ((letter == "c") ? 50 : 8)) begin
      put_str(",");
      put_num();
    end
  endfunction

  // Damages one spot of the line: overwrite, drop, insert or cut.
  function automatic void damage_line();
    string picks;
    int unsigned pos;
    picks = ",0@ +acd9-";
    if (line_q.size() == 0) return;
    pos = $urandom_range(0, line_q.size() - 1);
    case ($urandom_range(0, 3))
      0: line_q[pos] = 8'($urandom_range(0, 255));
      1: line_q.delete(pos);
      2: line_q.insert(pos, picks[$urandom_range(0, picks.len() - 1)]);
      default: begin
        while (line_q.size() > pos) void'(line_q.pop_back());
      end
    endcase
  endfunction

  task automatic make_line();
    int unsigned pick;
    line_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      repeat ($urandom_range(0, 10)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      // A few lines of the other format, mostly of the selected one.
      if ((pick < 10) ^ (cur_fmt == FmtNormal)) build_normal();
      else build_unified();
      if ($urandom_range(0, 99) < 18) damage_line();
    end
  endtask

  // Register writes happen only once the parser has gone quiet.
  task automatic set_format(logic f);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= f;
    cur_fmt = f;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_pressure(int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 45; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 45; end
      default: begin send_idle_pct = 7; stall_pct = 7; end
    endcase
  endtask

  task automatic run_directed();
    // Unified headers: empty line, default counts, range edges with
    // trailing bytes, overflow, truncated close, missing number, and a
    // failed line whose later bytes must be ignored.
    line_q.delete();
    send_line();
    send_text("@@ -1 +1 @@");
    line_q.delete();
    put_str("@@ -2147483647,0 +0,2147483647 @@ ");
    add_byte(8'hff);
    add_byte(8'h00);
    send_line();
    send_text("@@ -2147483648 +1 @@");
    send_text("@@ -3,4 +5 @");
    send_text("@@ -,4 +5 @@");
    send_text("x@@ -1 +1 @@");
    // A format write abandons the half-parsed line.
    line_q.delete();
    put_str("@@ -12,");
    send_bytes();
    set_format(FmtNormal);
    // Normal commands: every letter, comma rules, wrapping new count,
    // trailing junk, bad letter, missing numbers.
    send_text("1a2");
    send_text("3,5c7,9");
    send_text("3,5a7,9");
    send_text("7d6");
    send_text("4,9d3");
    send_text("10c8,2");
    send_text("2147483647c0");
    send_text("1a2x");
    send_text("1b2");
    send_text(",1a2");
    send_text("5a");
    send_text("0d0,4294967296");
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned phase_end;
    phase_no = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();

    while (items_sent < ItemTarget) begin
      set_format((phase_no % 2 == 0) ? FmtUnified : FmtNormal);
      set_pressure(phase_no % 4);
      phase_end = items_sent + PhaseItems;
      if (phase_no == 1) begin
        // Hold results back while short lines keep arriving.
        holds_asked++;
        repeat (10) begin
          line_q.delete();
          send_line();
        end
      end
      while (items_sent < phase_end) begin
        make_line();
        send_line();
        if (phase_no == 2 && items_sent >= phase_end - PhaseItems / 2
            && items_sent < phase_end - PhaseItems / 2 + 30) begin
          // Let the parser drain completely before going on.
          in_valid <= 1'b0;
          wait (pending == 0);
          @(negedge clk);
        end
      end
      phase_no++;
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
